[rtl/core/mbwc_pkg.sv]
// Package for the minute bucket window counter: ring size, field widths,
// saturation limits and opcodes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mbwc_pkg;

    // ring of per-minute buckets; the size is a power of two so that the
    // bucket of a minute is its low bits
    localparam int NUM_BUCKETS = 64;
    localparam int IDX_W       = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;

    // word fields
    localparam int MINUTE_W = 32;
    localparam int BYTES_W  = 24;
    localparam int WIN_W    = 7;
    localparam int LTOT_W   = 38;
    localparam int BTOT_W   = 54;

    // bucket counters
    localparam int LINES_W  = 32;
    localparam int BKT_B_W  = 48;
    localparam int ENTRY_W  = LINES_W + BKT_B_W;

    // accumulators hold up to 127 full buckets without wrapping
    localparam int ACC_L_W  = LINES_W + WIN_W;
    localparam int ACC_B_W  = BKT_B_W + WIN_W;

    localparam logic [LINES_W-1:0] LINES_MAX = {LINES_W{1'b1}};
    localparam logic [BKT_B_W-1:0] BYTES_MAX = {BKT_B_W{1'b1}};
    localparam logic [LTOT_W-1:0]  LTOT_MAX  = {LTOT_W{1'b1}};
    localparam logic [BTOT_W-1:0]  BTOT_MAX  = {BTOT_W{1'b1}};

    // opcodes
    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

endpackage

`default_nettype wire

[rtl/core/minute_bucket_window_counter_unit.sv]
// Minute bucket window counter: ring of per-minute line/byte buckets in one
// synchronous RAM, with record (advance, clear, add) and window query.
// Depends on mbwc_pkg.
//
//   channel  direction  word fields                                  handshake
//   s_       in         opcode, minute, byte_count, window_minutes   s_valid/s_ready
//   m_       out        line_total, byte_total (queries only)        m_valid/m_ready
//
// One word at a time. A record advances the ring, clears up to NUM_BUCKETS
// buckets, then reads and updates its own bucket; a query walks window_minutes
// buckets, one bucket RAM read per cycle. The bucket of a minute is its low bits.
// After reset a clearing pass writes every bucket with s_ready low. A stalled
// result sits in the output register; the next word is taken meanwhile and a
// query only waits at its final load.
`timescale 1ns / 1ps
`default_nettype none

module minute_bucket_window_counter_unit (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_opcode,
    input  wire logic [mbwc_pkg::MINUTE_W-1:0] s_minute,
    input  wire logic [mbwc_pkg::BYTES_W-1:0]  s_byte_count,
    input  wire logic [mbwc_pkg::WIN_W-1:0]    s_window_minutes,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [mbwc_pkg::LTOT_W-1:0]        m_line_total,
    output logic [mbwc_pkg::BTOT_W-1:0]        m_byte_total
);
    import mbwc_pkg::*;

    typedef enum logic [8:0] {
        ST_INIT   = 9'b0_0000_0001,
        ST_IDLE   = 9'b0_0000_0010,
        ST_PREP   = 9'b0_0000_0100,
        ST_CLEAR  = 9'b0_0000_1000,
        ST_READ   = 9'b0_0001_0000,
        ST_WRITE  = 9'b0_0010_0000,
        ST_SUM    = 9'b0_0100_0000,
        ST_DRAIN  = 9'b0_1000_0000,
        ST_FINISH = 9'b1_0000_0000
    } state_t;

    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(NUM_BUCKETS - 1);
    localparam logic [IDX_W:0]   CNT_FULL  = (IDX_W + 1)'(NUM_BUCKETS);
    localparam logic [33:0]      OLD_OFFS  = 34'(NUM_BUCKETS - 1);

    state_t state_reg, state_next;

    // latched word
    logic                 op_reg;
    logic [MINUTE_W-1:0]  minute_reg;
    logic [BYTES_W-1:0]   bytes_reg;
    logic [WIN_W-1:0]     win_reg;

    // ring position
    logic [MINUTE_W-1:0]  last_reg;
    logic [IDX_W-1:0]     last_idx_reg;
    logic [IDX_W-1:0]     now_idx_reg;

    // clearing
    logic [IDX_W-1:0]     init_idx_reg;
    logic [IDX_W-1:0]     clear_idx_reg;
    logic [IDX_W:0]       clear_cnt_reg;

    // window walk
    logic signed [33:0]   m_reg;
    logic signed [33:0]   oldest_reg;
    logic signed [33:0]   last_s;
    logic [IDX_W-1:0]     sum_idx_reg;
    logic [WIN_W-1:0]     sum_cnt_reg;
    logic                 take_reg;
    logic                 in_range;
    logic [ACC_L_W-1:0]   acc_lines_reg;
    logic [ACC_B_W-1:0]   acc_bytes_reg;

    // output register
    logic                 m_valid_reg;
    logic [LTOT_W-1:0]    line_out_reg;
    logic [BTOT_W-1:0]    byte_out_reg;
    logic                 out_load;

    // bucket RAM
    logic [ENTRY_W-1:0]   mem [NUM_BUCKETS];
    logic [ENTRY_W-1:0]   rd_data_reg;
    logic [IDX_W-1:0]     rd_addr;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [ENTRY_W-1:0]   wr_data;

    logic [LINES_W-1:0]   rd_lines;
    logic [BKT_B_W-1:0]   rd_bytes;
    logic [LINES_W-1:0]   upd_lines;
    logic [BKT_B_W:0]     bytes_sum;
    logic [BKT_B_W-1:0]   upd_bytes;
    logic [MINUTE_W-1:0]  gap;

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
        return (i == IDX_LAST) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_LAST : i - 1'b1;
    endfunction

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_line_total = line_out_reg;
    assign m_byte_total = byte_out_reg;

    assign rd_lines = rd_data_reg[ENTRY_W-1:BKT_B_W];
    assign rd_bytes = rd_data_reg[BKT_B_W-1:0];

    assign gap    = minute_reg - last_reg;
    assign last_s = $signed({2'b00, last_reg});
    assign in_range = (last_reg == '0) || ((m_reg >= oldest_reg) && (m_reg <= last_s));

    // saturating bucket update
    assign upd_lines = (rd_lines == LINES_MAX) ? rd_lines : rd_lines + 1'b1;
    assign bytes_sum = {1'b0, rd_bytes} + (BKT_B_W + 1)'(bytes_reg);
    assign upd_bytes = bytes_sum[BKT_B_W] ? BYTES_MAX : bytes_sum[BKT_B_W-1:0];

    assign out_load = (state_reg == ST_FINISH) && (!m_valid_reg || m_ready);

    // RAM port control
    always_comb begin
        rd_addr = (state_reg == ST_SUM) ? sum_idx_reg : now_idx_reg;
        wr_en   = 1'b0;
        wr_addr = now_idx_reg;
        wr_data = {upd_lines, upd_bytes};
        case (state_reg)
            ST_INIT: begin
                wr_en   = 1'b1;
                wr_addr = init_idx_reg;
                wr_data = '0;
            end
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = clear_idx_reg;
                wr_data = '0;
            end
            ST_WRITE: begin
                wr_en   = 1'b1;
            end
            default: begin
                wr_en   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT: begin
                if (init_idx_reg == IDX_LAST) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) state_next = ST_PREP;
            end
            ST_PREP: begin
                if (op_reg == OP_RECORD) begin
                    if (last_reg != '0 && minute_reg > last_reg) state_next = ST_CLEAR;
                    else state_next = ST_READ;
                end else begin
                    state_next = (win_reg == '0) ? ST_DRAIN : ST_SUM;
                end
            end
            ST_CLEAR: begin
                if (clear_cnt_reg == (IDX_W + 1)'(1)) state_next = ST_READ;
            end
            ST_READ:  state_next = ST_WRITE;
            ST_WRITE: state_next = ST_IDLE;
            ST_SUM: begin
                if (sum_cnt_reg == WIN_W'(1)) state_next = ST_DRAIN;
            end
            ST_DRAIN: state_next = ST_FINISH;
            ST_FINISH: begin
                if (out_load) state_next = ST_IDLE;
            end
            default: state_next = ST_INIT;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            init_idx_reg <= '0;
            last_reg     <= '0;
            last_idx_reg <= '0;
            take_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            take_reg  <= 1'b0;

            if (state_reg == ST_INIT) init_idx_reg <= idx_inc(init_idx_reg);

            // advance the ring position on a forward record
            if (state_reg == ST_PREP && op_reg == OP_RECORD &&
                (last_reg == '0 || minute_reg > last_reg)) begin
                last_reg     <= minute_reg;
                last_idx_reg <= now_idx_reg;
            end

            if (state_reg == ST_SUM) take_reg <= in_range;

            if (out_load) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                op_reg      <= s_opcode;
                minute_reg  <= s_minute;
                bytes_reg   <= s_byte_count;
                win_reg     <= s_window_minutes;
                now_idx_reg <= s_minute[IDX_W-1:0];
            end
            ST_PREP: begin
                clear_cnt_reg <= (gap >= MINUTE_W'(NUM_BUCKETS)) ? CNT_FULL : gap[IDX_W:0];
                clear_idx_reg <= idx_inc(last_idx_reg);
                m_reg         <= $signed({2'b00, minute_reg});
                oldest_reg    <= $signed({2'b00, last_reg} - OLD_OFFS);
                sum_idx_reg   <= now_idx_reg;
                sum_cnt_reg   <= win_reg;
            end
            ST_CLEAR: begin
                clear_cnt_reg <= clear_cnt_reg - 1'b1;
                clear_idx_reg <= idx_inc(clear_idx_reg);
            end
            ST_SUM: begin
                m_reg       <= m_reg - 34'sd1;
                sum_idx_reg <= idx_dec(sum_idx_reg);
                sum_cnt_reg <= sum_cnt_reg - 1'b1;
            end
            default: begin
            end
        endcase

        // accumulate the bucket read in the previous cycle
        if (state_reg == ST_PREP) begin
            acc_lines_reg <= '0;
            acc_bytes_reg <= '0;
        end else if (take_reg) begin
            acc_lines_reg <= acc_lines_reg + ACC_L_W'(rd_lines);
            acc_bytes_reg <= acc_bytes_reg + ACC_B_W'(rd_bytes);
        end

        // saturate into the output register
        if (out_load) begin
            line_out_reg <= (acc_lines_reg > ACC_L_W'(LTOT_MAX)) ? LTOT_MAX
                                                                : acc_lines_reg[LTOT_W-1:0];
            byte_out_reg <= (acc_bytes_reg > ACC_B_W'(BTOT_MAX)) ? BTOT_MAX
                                                                : acc_bytes_reg[BTOT_W-1:0];
        end
    end

endmodule

`default_nettype wire

[rtl/core/mbwc_checker.sv]
// Port-level checker for minute_bucket_window_counter_unit, bound to the
// top level below. Depends on mbwc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mbwc_checker (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    input  wire logic                          s_ready,
    input  wire logic                          s_opcode,
    input  wire logic [mbwc_pkg::MINUTE_W-1:0] s_minute,
    input  wire logic [mbwc_pkg::BYTES_W-1:0]  s_byte_count,
    input  wire logic [mbwc_pkg::WIN_W-1:0]    s_window_minutes,
    input  wire logic                          m_valid,
    input  wire logic                          m_ready,
    input  wire logic [mbwc_pkg::LTOT_W-1:0]   m_line_total,
    input  wire logic [mbwc_pkg::BTOT_W-1:0]   m_byte_total
);
    import mbwc_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_line_total) && $stable(m_byte_total))
        else $error("result word changed while stalled");

    // reset starts the clearing pass with nothing pending
    a_reset_busy: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("ready or valid right after reset");

    // one word at a time: busy in the cycle after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second word taken back to back");

    // every byte lands with a line, so no lines means no bytes
    a_bytes_need_lines: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_line_total == '0) |-> (m_byte_total == '0))
        else $error("byte total without any line");

endmodule

bind minute_bucket_window_counter_unit mbwc_checker u_mbwc_checker (.*);

`default_nettype wire
